@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

@@ design/hme_pkg.sv @@
// Types and constants of the histogram mode estimator.
package hme_pkg;

    localparam int MODE_W      = 2;
    localparam int VAR_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int BIU_W       = 9;
    localparam int SCALE_W     = 32;
    localparam int BIN_OUT_W   = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CELL_W      = COUNT_W + VALUE_W;

    localparam logic [MODE_W-1:0] MODE_COLLECT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESTIMATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BINS_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SCALE   = 4'd1;

    localparam logic [BIU_W-1:0]   BINS_IN_USE_RESET = 9'd256;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RESET   = 32'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [BIN_OUT_W-1:0] BIN_OUT_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COL_MUL,
        ST_COL_RD,
        ST_COL_WR,
        ST_SCAN,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [BIN_OUT_W-1:0] bin;
        logic                 oor;
    } result_t;

endpackage

@@ design/hme_if.sv @@
// Channel interfaces of the histogram mode estimator: samples, results, configuration.
interface hme_sample_if;
    logic                                valid;
    logic                                ready;
    logic [hme_pkg::MODE_W-1:0]          mode;
    logic [hme_pkg::VAR_W-1:0]           variable_index;
    logic signed [hme_pkg::VALUE_W-1:0]  sample_value;

    modport source (output valid, mode, variable_index, sample_value, input ready);
    modport sink (input valid, mode, variable_index, sample_value, output ready);
endinterface

interface hme_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [hme_pkg::VALUE_W-1:0]  estimate_value;
    logic [hme_pkg::BIN_OUT_W-1:0]       mode_bin;
    logic                                bin_out_of_range;

    modport source (output valid, estimate_value, mode_bin, bin_out_of_range, input ready);
    modport sink (input valid, estimate_value, mode_bin, bin_out_of_range, output ready);
endinterface

interface hme_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hme_pkg::CFG_INDEX_W-1:0]  reg_index;
    logic [hme_pkg::CFG_DATA_W-1:0]   write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink (input valid, reg_index, write_data, output ready);
endinterface

@@ design/histogram_mode_estimator.sv @@
// Top level of the histogram mode estimator: control sequencer around one cell memory.
//
//   channel   dir   handshake        beat contents
//   samples   in    valid / ready    mode, variable_index, sample_value
//   results   out   valid / ready    estimate_value, mode_bin, bin_out_of_range
//   cfg       in    valid / ready    reg_index, write_data (always ready)
//
// Each cell of the memory holds a 16-bit count and a 32-bit last sample; one item is in work at a time.
// A collect beat is accepted, multiplied, read, written back and then placed in the output register.
// A collect whose bin is out of range skips the write back.
// Estimate makes one memory read per bin in use; clear writes zero to every cell of the memory.
// After reset every cell of the memory is swept to zero while samples is held not ready.
// A waiting result does not block the next beat; only its own result waits for the output register.
module histogram_mode_estimator #(
    parameter int VARS = 16,
    parameter int BINS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    hme_sample_if.sink   samples,
    hme_result_if.source results,
    hme_cfg_if.sink      cfg
);

    localparam int CELLS = VARS * BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int BW    = $clog2(BINS);
    localparam int NW    = $clog2(BINS + 1);

    hme_pkg::state_t state_reg, state_next;

    logic [hme_pkg::BIU_W-1:0]   bins_in_use_reg;
    logic [hme_pkg::SCALE_W-1:0] bin_scale_reg;

    logic [hme_pkg::VAR_W-1:0]   var_reg;
    logic [hme_pkg::VALUE_W-1:0] raw_reg;
    logic [hme_pkg::VALUE_W-1:0] mag_reg;
    logic [63:0]                 prod_reg;
    logic [AW-1:0]               addr_reg;
    logic [AW-1:0]               sweep_reg;
    logic [NW-1:0]               rd_idx_reg;
    logic                        cmp_valid_reg;
    logic [BW-1:0]               cmp_idx_reg;
    logic [hme_pkg::COUNT_W-1:0] top_reg;
    logic [BW-1:0]               best_reg;
    logic [hme_pkg::VALUE_W-1:0] best_val_reg;
    hme_pkg::result_t            res_reg;
    hme_pkg::result_t            out_reg;
    logic                        out_valid_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [hme_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [hme_pkg::CELL_W-1:0]  ram_rdata;

    logic                        in_accept;
    logic                        in_var_ok;
    logic [hme_pkg::VALUE_W-1:0] in_raw;
    logic [hme_pkg::VALUE_W-1:0] in_mag;
    logic [NW-1:0]               n_bins;
    logic [AW-1:0]               base;
    logic [31:0]                 b_full;
    logic                        b_oor;
    logic [hme_pkg::BIN_OUT_W-1:0] b_sat;
    logic [BW-1:0]               pos;
    logic [AW-1:0]               col_addr;
    logic                        scan_issue;
    logic [AW-1:0]               scan_addr;
    logic                        scan_last;
    logic [hme_pkg::COUNT_W-1:0] cur_count;
    logic [hme_pkg::VALUE_W-1:0] cur_val;
    logic                        take;
    logic [BW-1:0]               fin_best;
    logic [hme_pkg::VALUE_W-1:0] fin_val;
    logic [hme_pkg::COUNT_W-1:0] count_inc;
    logic                        sweep_last;
    logic                        emit_free;

    hme_ram #(
        .WIDTH (hme_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_accept = samples.valid && samples.ready;
    assign in_var_ok = 32'(samples.variable_index) < 32'(VARS);
    assign in_raw    = unsigned'(samples.sample_value);
    assign in_mag    = in_raw[hme_pkg::VALUE_W-1] ? (~in_raw + 32'd1) : in_raw;

    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            n_bins = NW'(1);
        end
        else if (32'(bins_in_use_reg) > 32'(BINS))
        begin
            n_bins = NW'(BINS);
        end
        else
        begin
            n_bins = NW'(bins_in_use_reg);
        end
    end

    assign base     = AW'(32'(var_reg) * 32'(BINS));
    assign b_full   = prod_reg[63:32];
    assign b_oor    = b_full >= 32'(n_bins);
    assign b_sat    = (b_full > 32'(hme_pkg::BIN_OUT_MAX)) ? hme_pkg::BIN_OUT_MAX
                                                           : b_full[hme_pkg::BIN_OUT_W-1:0];
    assign pos      = raw_reg[hme_pkg::VALUE_W-1] ? BW'(32'(n_bins) - 32'd1 - b_full)
                                                  : BW'(b_full);
    assign col_addr = base + AW'(pos);

    assign scan_issue = rd_idx_reg < n_bins;
    assign scan_addr  = base + AW'(rd_idx_reg[BW-1:0]);
    assign scan_last  = cmp_valid_reg && (NW'(cmp_idx_reg) == (n_bins - NW'(1)));

    assign cur_count = ram_rdata[hme_pkg::CELL_W-1:hme_pkg::VALUE_W];
    assign cur_val   = ram_rdata[hme_pkg::VALUE_W-1:0];
    assign take      = (cmp_idx_reg == '0) || (cur_count > top_reg);
    assign fin_best  = take ? cmp_idx_reg : best_reg;
    assign fin_val   = take ? cur_val : best_val_reg;
    assign count_inc = (cur_count == hme_pkg::COUNT_MAX) ? cur_count
                                                         : cur_count + 16'd1;

    assign sweep_last = sweep_reg == AW'(CELLS - 1);
    assign emit_free  = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hme_pkg::ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = hme_pkg::ST_IDLE;
                end
            end
            hme_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (samples.mode == hme_pkg::MODE_CLEAR)
                    begin
                        state_next = hme_pkg::ST_CLEAR;
                    end
                    else if (samples.mode == hme_pkg::MODE_COLLECT && in_var_ok)
                    begin
                        state_next = hme_pkg::ST_COL_MUL;
                    end
                    else if (samples.mode == hme_pkg::MODE_ESTIMATE && in_var_ok)
                    begin
                        state_next = hme_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = hme_pkg::ST_EMIT;
                    end
                end
            end
            hme_pkg::ST_COL_MUL:
            begin
                state_next = hme_pkg::ST_COL_RD;
            end
            hme_pkg::ST_COL_RD:
            begin
                state_next = b_oor ? hme_pkg::ST_EMIT : hme_pkg::ST_COL_WR;
            end
            hme_pkg::ST_COL_WR:
            begin
                state_next = hme_pkg::ST_EMIT;
            end
            hme_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = hme_pkg::ST_EMIT;
                end
            end
            hme_pkg::ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = hme_pkg::ST_EMIT;
                end
            end
            hme_pkg::ST_EMIT:
            begin
                if (emit_free)
                begin
                    state_next = hme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hme_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = '0;
        ram_raddr = col_addr;
        unique case (state_reg)
            hme_pkg::ST_INIT, hme_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            hme_pkg::ST_COL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = {count_inc, raw_reg};
            end
            hme_pkg::ST_SCAN:
            begin
                ram_raddr = scan_addr;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign samples.ready = state_reg == hme_pkg::ST_IDLE;
    assign cfg.ready     = 1'b1;

    assign results.valid            = out_valid_reg;
    assign results.estimate_value   = signed'(out_reg.value);
    assign results.mode_bin         = out_reg.bin;
    assign results.bin_out_of_range = out_reg.oor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hme_pkg::ST_INIT;
            sweep_reg       <= '0;
            rd_idx_reg      <= '0;
            cmp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            bins_in_use_reg <= hme_pkg::BINS_IN_USE_RESET;
            bin_scale_reg   <= hme_pkg::BIN_SCALE_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == hme_pkg::ST_INIT || state_reg == hme_pkg::ST_CLEAR)
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + AW'(1);
            end

            if (in_accept)
            begin
                rd_idx_reg <= '0;
            end
            else if (state_reg == hme_pkg::ST_SCAN && scan_issue)
            begin
                rd_idx_reg <= rd_idx_reg + NW'(1);
            end
            cmp_valid_reg <= (state_reg == hme_pkg::ST_SCAN) && scan_issue;

            if (state_reg == hme_pkg::ST_EMIT && emit_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == hme_pkg::CFG_BINS_IN_USE)
                begin
                    bins_in_use_reg <= cfg.write_data[hme_pkg::BIU_W-1:0];
                end
                else if (cfg.reg_index == hme_pkg::CFG_BIN_SCALE)
                begin
                    bin_scale_reg <= cfg.write_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            var_reg <= samples.variable_index;
            raw_reg <= in_raw;
            mag_reg <= in_mag;
            res_reg <= '0;
        end

        if (state_reg == hme_pkg::ST_COL_MUL)
        begin
            prod_reg <= 64'(mag_reg) * 64'(bin_scale_reg);
        end

        if (state_reg == hme_pkg::ST_COL_RD)
        begin
            addr_reg    <= col_addr;
            res_reg.bin <= b_sat;
            res_reg.oor <= b_oor;
        end

        cmp_idx_reg <= rd_idx_reg[BW-1:0];
        if (cmp_valid_reg)
        begin
            if (take)
            begin
                top_reg      <= cur_count;
                best_reg     <= cmp_idx_reg;
                best_val_reg <= cur_val;
            end
            if (scan_last)
            begin
                res_reg.value <= fin_val;
                res_reg.bin   <= (32'(fin_best) > 32'(hme_pkg::BIN_OUT_MAX))
                                 ? hme_pkg::BIN_OUT_MAX : hme_pkg::BIN_OUT_W'(fin_best);
            end
        end

        if (state_reg == hme_pkg::ST_EMIT && emit_free)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

@@ design/hme_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module hme_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/hme_checker.sv @@
// Port-level checker of the histogram mode estimator and its bind to the top level.
`include "assert_macros.svh"

module hme_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [hme_pkg::VALUE_W-1:0]        estimate_value,
    input logic [hme_pkg::BIN_OUT_W-1:0]      mode_bin,
    input logic                               bin_out_of_range
);

    // A result beat that is not taken must hold its contents.
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(estimate_value) && $stable(mode_bin) && $stable(bin_out_of_range), "result beat changed while stalled")

    // The block works on one sample beat at a time.
    `ASSERT_CLK(a_one_in_work, in_valid && in_ready |=> !in_ready, "second beat accepted while one is in work")

    // A skipped sample carries no estimate.
    `ASSERT_NEVER(a_oor_no_value, out_valid && bin_out_of_range && (estimate_value != '0), "skipped sample carries a value")

    // A skipped sample always has a bin index of at least one.
    `ASSERT_NEVER(a_oor_bin_nonzero, out_valid && bin_out_of_range && (mode_bin == '0), "skipped sample with bin zero")

endmodule

bind histogram_mode_estimator hme_checker u_hme_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (samples.valid),
    .in_ready         (samples.ready),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .estimate_value   (results.estimate_value),
    .mode_bin         (results.mode_bin),
    .bin_out_of_range (results.bin_out_of_range)
);

@@ dv/histogram_mode_estimator_tb.sv @@
// Self-checking testbench of the histogram mode estimator with driver, monitor and predictor.
module histogram_mode_estimator_tb;
    import hme_pkg::*;

    localparam int VARS = 16;
    localparam int BINS = 256;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VAR_W-1:0]   row;
        logic [VALUE_W-1:0] sample_word;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;

    hme_sample_if samples_ch();
    hme_result_if results_ch();
    hme_cfg_if cfg_ch();

    histogram_mode_estimator #(
        .VARS(VARS),
        .BINS(BINS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .results(results_ch),
        .cfg(cfg_ch)
    );

    logic [COUNT_W-1:0] hit_count [VARS*BINS];
    logic [VALUE_W-1:0] last_sample [VARS*BINS];
    logic [BIU_W-1:0] bins_reg;
    logic [SCALE_W-1:0] scale_reg;

    beat_t queued_beats [$];
    result_t pending_results [$];
    beat_t next_beat;
    result_t want;
    int mismatches = 0;
    int stall_cycles = 0;

    always #5 clk = ~clk;

    function automatic int unsigned used_bins();
        if (bins_reg == 0)
        begin
            return 1;
        end
        if (bins_reg > BINS)
        begin
            return BINS;
        end
        return bins_reg;
    endfunction

    function automatic result_t predict_histogram_result(logic [MODE_W-1:0] mode,
                                                         logic [VAR_W-1:0] row,
                                                         logic [VALUE_W-1:0] sample_word);
        result_t res;
        logic [31:0] mag;
        logic [63:0] product;
        logic [31:0] bin_idx;
        int unsigned n;
        int unsigned base;
        int unsigned pos;
        int unsigned top;
        int unsigned best;
        res = '0;
        n = used_bins();
        base = row * BINS;
        case (mode)
            MODE_CLEAR:
            begin
                for (int i = 0; i < VARS*BINS; i++)
                begin
                    hit_count[i] = '0;
                    last_sample[i] = '0;
                end
            end
            MODE_COLLECT:
            begin
                mag = sample_word[31] ? (~sample_word + 32'd1) : sample_word;
                product = {32'd0, mag} * {32'd0, scale_reg};
                bin_idx = product[63:32];
                res.bin = (bin_idx > 255) ? BIN_OUT_MAX : bin_idx[7:0];
                if (bin_idx >= n)
                begin
                    res.oor = 1'b1;
                end
                else
                begin
                    pos = sample_word[31] ? (n - 1 - bin_idx) : bin_idx;
                    if (hit_count[base + pos] != COUNT_MAX)
                    begin
                        hit_count[base + pos] = hit_count[base + pos] + 1'b1;
                    end
                    last_sample[base + pos] = sample_word;
                end
            end
            MODE_ESTIMATE:
            begin
                top = 0;
                best = 0;
                for (int unsigned j = 0; j < n; j++)
                begin
                    if (hit_count[base + j] > top)
                    begin
                        top = hit_count[base + j];
                        best = j;
                    end
                end
                res.value = last_sample[base + best];
                res.bin = best[7:0];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int unsigned r;
        int unsigned n;
        int unsigned target;
        logic [63:0] span;
        logic [31:0] mag;
        n = used_bins();
        r = $urandom_range(99);
        if (r < 3)
        begin
            b.mode = MODE_CLEAR;
        end
        else if (r < 25)
        begin
            b.mode = MODE_ESTIMATE;
        end
        else
        begin
            b.mode = MODE_COLLECT;
        end
        b.row = ($urandom_range(99) < 60) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        if (b.mode != MODE_COLLECT || $urandom_range(99) < 20)
        begin
            b.sample_word = $urandom;
        end
        else
        begin
            target = (n <= 8 || $urandom_range(1)) ? $urandom_range(n + 1) : $urandom_range(7);
            span = (({32'd0, target} << 32) + {32'd0, $urandom}) / {32'd0, scale_reg};
            mag = (span > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : span[31:0];
            b.sample_word = $urandom_range(1) ? (~mag + 32'd1) : mag;
        end
        return b;
    endfunction

    task automatic push_beat(logic [MODE_W-1:0] mode, logic [VAR_W-1:0] row,
                             logic [VALUE_W-1:0] sample_word);
        beat_t b;
        b.mode = mode;
        b.row = row;
        b.sample_word = sample_word;
        queued_beats.push_back(b);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.write_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (index == CFG_BINS_IN_USE)
        begin
            bins_reg = data[BIU_W-1:0];
        end
        else if (index == CFG_BIN_SCALE)
        begin
            scale_reg = data[SCALE_W-1:0];
        end
    endtask

    // The falling edge sees the queue, valid and predictions after the rising edge settled.
    task automatic drain();
        while (queued_beats.size() != 0 || samples_ch.valid || pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic flag_mismatch(string field, logic [31:0] expected_word,
                                 logic [31:0] actual_word);
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, field, expected_word, actual_word);
    endtask

    // Driver: a beat is predicted at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                pending_results.push_back(predict_histogram_result(samples_ch.mode,
                    samples_ch.variable_index, samples_ch.sample_value));
            end
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (queued_beats.size() != 0 && (quiet || $urandom_range(99) >= 32))
                begin
                    next_beat = queued_beats.pop_front();
                    samples_ch.valid <= 1'b1;
                    samples_ch.mode <= next_beat.mode;
                    samples_ch.variable_index <= next_beat.row;
                    samples_ch.sample_value <= next_beat.sample_word;
                end
                else
                begin
                    samples_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
        end
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no expectation, expected none, actual %0h %0h %0b",
                             $time, results_ch.estimate_value, results_ch.mode_bin,
                             results_ch.bin_out_of_range);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (results_ch.estimate_value !== want.value)
                    begin
                        flag_mismatch("estimate_value", want.value, results_ch.estimate_value);
                    end
                    if (results_ch.mode_bin !== want.bin)
                    begin
                        flag_mismatch("mode_bin", want.bin, results_ch.mode_bin);
                    end
                    if (results_ch.bin_out_of_range !== want.oor)
                    begin
                        flag_mismatch("bin_out_of_range", want.oor, results_ch.bin_out_of_range);
                    end
                end
            end
            results_ch.ready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (samples_ch.valid && samples_ch.ready)
            || (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [BIU_W-1:0] plan_bins;
        logic [SCALE_W-1:0] plan_scale;
        rst_n = 1'b0;
        quiet = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.mode = MODE_COLLECT;
        samples_ch.variable_index = '0;
        samples_ch.sample_value = '0;
        results_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = CFG_BINS_IN_USE;
        cfg_ch.write_data = '0;
        bins_reg = BINS_IN_USE_RESET;
        scale_reg = BIN_SCALE_RESET;
        for (int i = 0; i < VARS*BINS; i++)
        begin
            hit_count[i] = '0;
            last_sample[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!samples_ch.ready)
        begin
            @(posedge clk);
        end
        write_reg(CFG_BINS_IN_USE, 32'(BINS_IN_USE_RESET));
        write_reg(CFG_BIN_SCALE, BIN_SCALE_RESET);

        // Bin edges, out-of-range magnitudes, the most negative sample and mirrored bins.
        push_beat(MODE_COLLECT, 4'd0, 32'h0000_0000);
        push_beat(MODE_COLLECT, 4'd0, 32'h0001_0000);
        push_beat(MODE_COLLECT, 4'd0, 32'h0001_8000);
        push_beat(MODE_COLLECT, 4'd0, 32'h00FF_FFFF);
        push_beat(MODE_COLLECT, 4'd0, 32'h0100_0000);
        push_beat(MODE_COLLECT, 4'd0, 32'h7FFF_FFFF);
        push_beat(MODE_COLLECT, 4'd0, 32'h8000_0000);
        push_beat(MODE_COLLECT, 4'd0, 32'hFFFF_FFFF);
        push_beat(MODE_COLLECT, 4'd0, 32'hFFFF_0000);
        push_beat(MODE_COLLECT, 4'd0, 32'hFF00_0001);
        push_beat(MODE_ESTIMATE, 4'd0, 32'h0000_0000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0005_0000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0005_4000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0005_8000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0002_0000);
        push_beat(MODE_ESTIMATE, 4'd15, 32'hFFFF_FFFF);
        push_beat(MODE_ESTIMATE, 4'd7, 32'h0000_0000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0002_0000);
        push_beat(MODE_COLLECT, 4'd15, 32'h0002_0001);
        push_beat(MODE_ESTIMATE, 4'd15, 32'h0000_0000);
        push_beat(MODE_CLEAR, 4'd0, 32'h0000_0000);
        push_beat(MODE_ESTIMATE, 4'd0, 32'h0000_0000);
        push_beat(MODE_COLLECT, 4'd3, 32'h0003_FFFF);
        push_beat(MODE_ESTIMATE, 4'd3, 32'h0000_0000);
        drain();

        // Repeated hits on one bin with both sides always ready.
        quiet <= 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            push_beat(MODE_COLLECT, 4'd9, {16'h0001, 16'($urandom)});
        end
        push_beat(MODE_ESTIMATE, 4'd9, 32'h0000_0000);
        drain();
        quiet <= 1'b0;

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    plan_bins = 9'd1;
                    plan_scale = 32'd1;
                end
                1:
                begin
                    plan_bins = 9'd256;
                    plan_scale = 32'hFFFF_FFFF;
                end
                2:
                begin
                    plan_bins = 9'd2;
                    plan_scale = 32'h0002_0000;
                end
                3:
                begin
                    plan_bins = 9'd100;
                    plan_scale = 32'h0000_8000;
                end
                4:
                begin
                    plan_bins = 9'd255;
                    plan_scale = 32'h0001_0000;
                end
                5, 6:
                begin
                    plan_bins = 9'($urandom_range(256, 1));
                    plan_scale = $urandom_range(32'h0004_0000, 32'h0000_0100);
                end
                default:
                begin
                    plan_bins = BINS_IN_USE_RESET;
                    plan_scale = BIN_SCALE_RESET;
                end
            endcase
            write_reg(CFG_BINS_IN_USE, {23'd0, plan_bins});
            write_reg(CFG_BIN_SCALE, plan_scale);
            repeat (90) queued_beats.push_back(random_beat());
            drain();
        end

        repeat (300) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/hme_pkg.sv
design/hme_if.sv
design/hme_ram.sv
design/histogram_mode_estimator.sv
design/hme_checker.sv
dv/histogram_mode_estimator_tb.sv
